[sv/bctc_pkg.sv]
// shared types and constants for the brightness/contrast tone curve block
// curve tables in thousandths and their Q2.14 form; no dependencies
package bctc_pkg;

  typedef logic [0:255][15:0] curve_t;

  typedef enum logic [2:0] {
    ST_FILL, ST_PRE, ST_DIVB, ST_WAITB, ST_DIVC, ST_WAITC, ST_CHK, ST_RUN
  } seq_state_e;

  localparam logic [1:0] REG_BRIGHT   = 2'd0;
  localparam logic [1:0] REG_CONTRAST = 2'd1;
  localparam logic [1:0] REG_COARSE   = 2'd2;

  localparam curve_t HUMP_T = '{
    0,4,8,12,16,20,24,27,31,35,39,43,47,51,55,59,
    63,66,69,73,77,80,83,86,90,93,97,100,103,107,110,113,
    117,120,124,127,131,134,138,141,145,148,151,154,157,160,163,166,
    169,172,175,178,181,184,187,190,193,196,199,202,205,208,211,214,
    217,220,223,226,229,232,235,238,240,243,246,249,251,254,256,259,
    262,264,267,269,271,274,276,278,280,283,285,287,289,291,293,295,
    297,298,300,302,304,305,307,309,310,311,313,314,316,317,318,319,
    320,321,322,323,324,325,326,327,328,328,329,329,329,330,330,330,
    330,330,330,329,329,329,328,328,327,326,325,324,323,322,321,320,
    319,318,317,316,314,313,311,310,309,307,305,304,302,300,298,297,
    295,293,291,289,287,285,283,280,278,276,274,271,269,267,264,262,
    259,256,254,251,249,246,243,240,238,235,232,229,226,223,220,217,
    214,211,208,205,202,199,196,193,190,187,184,181,178,175,172,169,
    166,163,160,157,154,151,148,145,141,138,134,131,127,124,120,117,
    113,110,107,103,100,97,93,90,86,83,80,77,73,69,66,63,
    59,55,51,47,43,39,35,31,27,24,20,16,12,8,4,0};

  localparam curve_t OGEE_T = '{
    0,-4,-7,-11,-14,-18,-21,-25,-28,-32,-35,-39,-42,-46,-49,-52,
    -55,-58,-61,-64,-68,-71,-74,-77,-81,-84,-87,-89,-92,-95,-97,-100,
    -103,-105,-108,-110,-112,-114,-115,-116,-117,-118,-118,-119,-119,-119,-120,-120,
    -120,-120,-119,-119,-119,-118,-118,-117,-117,-116,-116,-115,-114,-113,-112,-111,
    -109,-107,-106,-104,-103,-101,-100,-98,-97,-95,-94,-92,-90,-88,-87,-85,
    -83,-81,-80,-78,-76,-74,-73,-71,-70,-68,-67,-65,-63,-61,-60,-58,
    -56,-54,-53,-51,-49,-47,-46,-44,-42,-40,-38,-36,-34,-32,-31,-29,
    -27,-25,-24,-22,-20,-18,-17,-15,-13,-11,-10,-8,-6,-4,-3,-1,
    1,3,4,6,8,10,11,13,15,17,18,20,22,24,25,27,
    29,31,32,34,36,38,40,42,44,46,47,49,51,53,54,56,
    58,60,61,63,65,67,68,70,71,73,74,76,78,80,81,83,
    85,87,88,90,92,94,95,97,98,100,101,103,104,106,107,109,
    111,112,113,114,115,116,116,117,117,118,118,119,119,119,120,120,
    120,120,119,119,119,118,118,117,116,115,114,112,110,108,105,103,
    100,97,95,92,89,87,84,81,77,74,71,68,64,61,58,55,
    52,49,46,42,39,35,32,28,25,21,18,14,11,7,4,0};

  // thousandths to Q2.14, rounded half away from zero
  function automatic curve_t to_q14(input curve_t t);
    curve_t r;
    longint v;
    longint m;
    longint q;
    for (int i = 0; i < 256; i++) begin
      v = longint'($signed(t[i]));
      m = (v < 0) ? -v : v;
      q = (m * 16384 + 500) / 1000;
      r[i] = 16'((v < 0) ? -q : q);
    end
    return r;
  endfunction

  localparam curve_t HUMP_Q14 = to_q14(HUMP_T);
  localparam curve_t OGEE_Q14 = to_q14(OGEE_T);

endpackage

[sv/bctc_if.sv]
// pixel channel interfaces for the tone curve block
// valid/ready handshake with three 8-bit levels; no dependencies
interface bctc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bctc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

[sv/brightness_contrast_tone_curve.sv]
// top level of the brightness/contrast tone curve block
// uses bctc_pkg, bctc_if, bctc_ram and bctc_div
//
// Maps each channel of an RGB pixel through level/FS + b*B + c*C, clamped and
// rounded. One pixel per clock is accepted while the output is not stalled
// and the sequencer is in ST_RUN; each result passes in order through the
// ram read, multiply, full-scale scaling and clamp into the output register.
// After reset a fill pass writes the curve tables into one ram per channel;
// no pixel is taken meanwhile. After each configuration write the prescaled
// fractions are recomputed with ready low; when the overflow or underflow
// prescale applies, a shared serial divider runs once per fraction.
module brightness_contrast_tone_curve #(
  parameter int LEVELS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bctc_in_if.sink     in_ch,
  bctc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bctc_pkg::*;

  localparam int     Fs   = LEVELS - 1;
  localparam int     FsW  = $clog2(LEVELS) + 1;
  localparam longint One29 = 64'sd1 <<< 29;
  localparam longint Den  = 100 * longint'(Fs);
  localparam longint Num1 = 99 * longint'(Fs) - 21600;
  localparam longint Num2 = 4000 - longint'(Fs);
  localparam longint Thr1 = (Num1 <= 0) ? 0 : (Num1 * One29 + Den / 2) / Den;
  localparam longint Thr2 = (Num2 <= 0) ? 0 : (Num2 * One29 + Den / 2) / Den;
  localparam longint PosD = 2 * longint'(Fs);
  localparam longint NegD = 10 * longint'(Fs);
  localparam logic signed [32:0]    Thr1S = 33'(Thr1);
  localparam logic signed [32:0]    Thr2S = 33'(Thr2);
  localparam logic signed [FsW-1:0] FsS   = FsW'(Fs);
  localparam logic signed [47:0]    TopX  = 48'(longint'(Fs) * One29);
  localparam logic signed [15:0] H216 = HUMP_Q14[216];
  localparam logic signed [15:0] O216 = OGEE_Q14[216];
  localparam logic signed [15:0] H40  = HUMP_Q14[40];
  localparam logic signed [15:0] O40  = OGEE_Q14[40];
  // 9 * ceil(2^22 / 10): x*9/10 is (x * this) >> 22, exact for 16-bit magnitudes
  localparam logic [21:0]        Nine10 = 22'd3774879;

  // coarse contrast ramps, rounded half up and saturated to Q2.14
  function automatic curve_t build_ramp(input bit pos);
    curve_t r;
    longint n;
    longint q;
    for (int l = 0; l < 256; l++) begin
      if (pos) begin
        n = 2 * (32768 * (2 * longint'(l) - Fs)) + Fs;
        q = n / PosD;
        if ((n % PosD) != 0 && n < 0) q = q - 1;
      end else begin
        n = 2 * (16384 * (4 * longint'(l) - 2 * Fs)) + 5 * Fs;
        q = n / NegD;
        if ((n % NegD) != 0 && n < 0) q = q - 1;
      end
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r[l] = 16'(q);
    end
    return r;
  endfunction

  // nine tenths, truncated toward zero
  function automatic logic signed [15:0] shrink9(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [38:0] prod;
    logic [15:0] q;
    mag  = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    prod = 39'(mag) * 39'(Nine10);
    q    = prod[37:22];
    return v[15] ? 16'(-q) : q;
  endfunction

  localparam curve_t RampPos = build_ramp(1'b1);
  localparam curve_t RampNeg = build_ramp(1'b0);

  // configuration registers
  logic signed [15:0] b_q, c_q;
  logic               coarse_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q      <= '0;
      c_q      <= '0;
      coarse_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BRIGHT:   b_q      <= pwdata[15:0];
        REG_CONTRAST: c_q      <= pwdata[15:0];
        REG_COARSE:   coarse_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BRIGHT:   prdata = {16'b0, b_q};
      REG_CONTRAST: prdata = {16'b0, c_q};
      REG_COARSE:   prdata = {31'b0, coarse_q};
      default:      prdata = '0;
    endcase
  end

  // prescale sequencer
  seq_state_e         state_q, state_d;
  logic [7:0]         fill_q;
  logic signed [15:0] eb_q, ec_q, eb_d, ec_d;
  logic [29:0]        fac_q, fac_d;
  logic [47:0]        den_q, den_d;

  logic signed [31:0] pb1, pc1, pb2, pc2, pbc;
  logic signed [32:0] sum_hi, neg_lo;
  logic               apply1, apply2, apply3;
  logic [31:0]        pbc_mag;
  logic signed [15:0] op;
  logic [15:0]        op_mag;
  logic [15:0]        q16;
  logic signed [15:0] q_signed;
  logic               div_start, div_done;
  logic [47:0]        div_quot, div_dvd;

  assign pb1    = b_q * H216;
  assign pc1    = c_q * O216;
  assign pb2    = b_q * H40;
  assign pc2    = c_q * O40;
  assign sum_hi = {pb1[31], pb1} + {pc1[31], pc1};
  assign neg_lo = -({pb2[31], pb2} + {pc2[31], pc2});
  assign apply1 = (b_q > 0) && (c_q > 0) && (sum_hi > Thr1S) && (sum_hi > 0);
  assign apply2 = (b_q < 0) && (c_q > 0) && (neg_lo > Thr2S) && (neg_lo > 0);

  assign pbc     = eb_q * ec_q;
  assign pbc_mag = pbc[31] ? 32'(-pbc) : 32'(pbc);
  assign apply3  = (ec_q < 0) && ((35'(pbc_mag) * 35'd5) > (35'd1 << 32));

  assign op       = (state_q == ST_DIVC || state_q == ST_WAITC) ? ec_q : eb_q;
  assign op_mag   = op[15] ? 16'(-op) : 16'(op);
  assign div_dvd  = 48'(op_mag) * 48'(fac_q);
  assign q16      = div_quot[15:0];
  assign q_signed = op[15] ? 16'(-q16) : 16'(q16);

  always_comb begin
    state_d   = state_q;
    eb_d      = eb_q;
    ec_d      = ec_q;
    fac_d     = fac_q;
    den_d     = den_q;
    div_start = 1'b0;
    case (state_q)
      ST_FILL: begin
        if (fill_q == 8'd255) state_d = ST_PRE;
      end
      ST_PRE: begin
        eb_d  = b_q;
        ec_d  = c_q;
        fac_d = apply1 ? 30'(Thr1) : 30'(Thr2);
        den_d = apply1 ? 48'(sum_hi) : 48'(neg_lo);
        if (coarse_q) state_d = ST_RUN;
        else if (apply1 || apply2) state_d = ST_DIVB;
        else state_d = ST_CHK;
      end
      ST_DIVB: begin
        div_start = 1'b1;
        state_d   = ST_WAITB;
      end
      ST_WAITB: begin
        if (div_done) begin
          eb_d    = q_signed;
          state_d = ST_DIVC;
        end
      end
      ST_DIVC: begin
        div_start = 1'b1;
        state_d   = ST_WAITC;
      end
      ST_WAITC: begin
        if (div_done) begin
          ec_d    = q_signed;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        // shrink by nine tenths for strong negative contrast
        if (apply3) begin
          eb_d = shrink9(eb_q);
          ec_d = shrink9(ec_q);
        end
        state_d = ST_RUN;
      end
      ST_RUN: ;
      default: state_d = ST_PRE;
    endcase
    if (cfg_wr && state_q != ST_FILL) state_d = ST_PRE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FILL) fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    eb_q  <= eb_d;
    ec_q  <= ec_d;
    fac_q <= fac_d;
    den_q <= den_d;
  end

  bctc_div #(.W(48)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // pixel pipeline
  logic                en;
  logic                out_v_q, v1_q, v2_q, v3_q;
  logic [2:0][7:0]     lvl_in, lvl1_q, lvl2_q, lvl3_q;
  logic [2:0][63:0]    rd;
  logic [63:0]         fill_data;
  logic [2:0][15:0]    bsel, csel;
  logic [2:0][31:0]    pb_q, pc_q;
  logic [2:0][47:0]    m_q;
  logic [2:0][7:0]     res_q;
  logic signed [47:0]  x [3];
  logic signed [47:0]  xc [3];
  logic [47:0]         r [3];
  logic signed [32:0]  s [3];
  logic [2:0][7:0]     res_d;

  assign en           = !out_v_q || out_ch.ready;
  assign in_ch.ready  = (state_q == ST_RUN) && en;
  assign lvl_in       = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
  assign fill_data    = {HUMP_Q14[fill_q], OGEE_Q14[fill_q],
                         RampPos[fill_q], RampNeg[fill_q]};

  for (genvar k = 0; k < 3; k++) begin : g_lane
    bctc_ram #(.W(64), .DEPTH(256)) u_ram (
      .clk_i   (clk_i),
      .we_i    (state_q == ST_FILL),
      .waddr_i (fill_q),
      .wdata_i (fill_data),
      .re_i    (en),
      .raddr_i (lvl_in[k]),
      .rdata_o (rd[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (coarse_q) begin
        bsel[k] = (eb_q != 0) ? 16'sd8192 : 16'sd0;
        csel[k] = (ec_q > 0) ? rd[k][31:16] : ((ec_q < 0) ? rd[k][15:0] : 16'd0);
      end else begin
        bsel[k] = rd[k][63:48];
        csel[k] = rd[k][47:32];
      end
      s[k]  = {pb_q[k][31], pb_q[k]} + {pc_q[k][31], pc_q[k]};
      x[k]  = $signed({11'b0, lvl3_q[k], 29'b0}) + $signed(m_q[k]);
      xc[k] = (x[k] < 0) ? 48'sd0 : ((x[k] > TopX) ? TopX : x[k]);
      r[k]  = (48'(xc[k]) + (48'd1 << 28)) >> 29;
      res_d[k] = (r[k] > 48'd255) ? 8'd255 : r[k][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_ch.valid && in_ch.ready;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl1_q <= lvl_in;
      lvl2_q <= lvl1_q;
      lvl3_q <= lvl2_q;
      res_q  <= res_d;
      for (int k = 0; k < 3; k++) begin
        pb_q[k] <= eb_q * $signed(bsel[k]);
        pc_q[k] <= ec_q * $signed(csel[k]);
        m_q[k]  <= s[k] * FsS;
      end
    end
  end

  assign out_ch.valid     = out_v_q;
  assign out_ch.red_out   = res_q[0];
  assign out_ch.green_out = res_q[1];
  assign out_ch.blue_out  = res_q[2];
endmodule

[sv/bctc_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module bctc_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sv/bctc_div.sv]
// unsigned restoring divider, one quotient bit per cycle
// no dependencies
module bctc_div #(
  parameter int W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    tmp;
  logic          ge;

  assign tmp = {rem_q, quo_q[W-1]};
  assign ge  = tmp >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? W'(tmp - {1'b0, div_q}) : W'(tmp);
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

[tb/sv/tb.sv]
// testbench for the brightness/contrast tone curve block
// drives pixels and register writes, predicts each output pixel; uses bctc_pkg, bctc_if
module tb;
  import bctc_pkg::*;

  localparam longint FS = 255;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bctc_in_if  pix_in();
  bctc_out_if pix_out();

  brightness_contrast_tone_curve uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(pix_in.sink), .out_ch(pix_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // directed rows: fixed expectation only where obvious
  typedef struct {
    pixel_t pix;
    bit     known;
    pixel_t want;
  } pix_row_t;

  longint bright_q15, contrast_q15;
  bit     coarse_sel;
  pixel_t expected_pixels[$];
  int     fail_cnt;
  bit     calm;

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_out.ready = 1'b0;
  end

  function automatic longint rom_to_q14(input logic [15:0] t);
    longint v, m, q;
    v = longint'($signed(t));
    m = (v < 0) ? -v : v;
    q = (m * 16384 + 500) / 1000;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint div_half_up(input longint num, input longint den);
    longint n, d, q;
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip_q14(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint q29_threshold(input longint num, input longint den);
    if (num <= 0) return 0;
    return (num * (64'sd1 <<< 29) + den / 2) / den;
  endfunction

  function automatic logic [7:0] tone_level(input logic [7:0] lvl, input longint b,
                                            input longint c, input bit crs);
    longint bc, cc, x, top, l, r;
    l = longint'(lvl);
    if (crs) begin
      bc = (b != 0) ? 8192 : 0;
      if (c > 0) cc = clip_q14(div_half_up(32768 * (2 * l - FS), FS));
      else if (c < 0) cc = clip_q14(div_half_up(16384 * (4 * l - 2 * FS), 5 * FS));
      else cc = 0;
    end else begin
      bc = rom_to_q14(HUMP_T[lvl]);
      cc = rom_to_q14(OGEE_T[lvl]);
    end
    x = l * (64'sd1 <<< 29) + FS * (b * bc + c * cc);
    top = FS * (64'sd1 <<< 29);
    if (x < 0) x = 0;
    if (x > top) x = top;
    r = (x + (64'sd1 <<< 28)) >>> 29;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic pixel_t tone_pixel(input pixel_t p);
    longint b, c, thr, sum, neg, prod;
    pixel_t q;
    b = bright_q15;
    c = contrast_q15;
    if (!coarse_sel) begin
      if (b > 0 && c > 0) begin
        thr = q29_threshold(99 * FS - 21600, 100 * FS);
        sum = b * rom_to_q14(HUMP_T[216]) + c * rom_to_q14(OGEE_T[216]);
        if (sum > thr && sum > 0) begin
          b = b * thr / sum;
          c = c * thr / sum;
        end
      end
      if (b < 0 && c > 0) begin
        thr = q29_threshold(4000 - FS, 100 * FS);
        neg = -(b * rom_to_q14(HUMP_T[40]) + c * rom_to_q14(OGEE_T[40]));
        if (neg > thr && neg > 0) begin
          b = b * thr / neg;
          c = c * thr / neg;
        end
      end
      if (c < 0) begin
        prod = b * c;
        if (prod < 0) prod = -prod;
        if (5 * prod > 4 * (64'sd1 <<< 30)) begin
          b = b * 9 / 10;
          c = c * 9 / 10;
        end
      end
    end
    q.red = tone_level(p.red, b, c, coarse_sel);
    q.green = tone_level(p.green, b, c, coarse_sel);
    q.blue = tone_level(p.blue, b, c, coarse_sel);
    return q;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 11);
  endfunction

  // output side: random stalls, compare against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel %h %h %h", pix_out.red_out, pix_out.green_out,
                 pix_out.blue_out);
          fail_cnt++;
        end else begin
          pixel_t e;
          e = expected_pixels.pop_front();
          if (pix_out.red_out !== e.red) begin
            $error("red_out expected %0d got %0d", e.red, pix_out.red_out);
            fail_cnt++;
          end
          if (pix_out.green_out !== e.green) begin
            $error("green_out expected %0d got %0d", e.green, pix_out.green_out);
            fail_cnt++;
          end
          if (pix_out.blue_out !== e.blue) begin
            $error("blue_out expected %0d got %0d", e.blue, pix_out.blue_out);
            fail_cnt++;
          end
        end
      end
      pix_out.ready <= !idle_now();
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHT:   bright_q15 = longint'($signed(val[15:0]));
      REG_CONTRAST: contrast_q15 = longint'($signed(val[15:0]));
      default:      coarse_sel = val[0];
    endcase
  endtask

  task automatic set_tone(input logic [15:0] b, input logic [15:0] c, input bit crs);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    write_reg(REG_BRIGHT, {16'h0, b});
    write_reg(REG_CONTRAST, {16'h0, c});
    write_reg(REG_COARSE, {31'h0, crs});
  endtask

  // pixel stays up until taken; valid is never dropped and re-raised in one step
  task automatic send_pixel(input pixel_t p, input bit known, input pixel_t want);
    while (idle_now()) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= p.red;
    pix_in.green_in <= p.green;
    pix_in.blue_in <= p.blue;
    do @(posedge clk_i); while (!pix_in.ready);
    expected_pixels.push_back(known ? want : tone_pixel(p));
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'(24'($urandom));
    return p;
  endfunction

  initial begin
    pix_row_t rows[$];
    logic [15:0] b_pick, c_pick;
    calm = 1'b0;
    fail_cnt = 0;
    bright_q15 = 0;
    contrast_q15 = 0;
    coarse_sel = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the curve is the identity
    rows = '{
      '{'{8'd0, 8'd255, 8'd128}, 1'b1, '{8'd0, 8'd255, 8'd128}},
      '{'{8'd255, 8'd0, 8'd1}, 1'b1, '{8'd255, 8'd0, 8'd1}},
      '{'{8'hAA, 8'h55, 8'hFF}, 1'b1, '{8'hAA, 8'h55, 8'hFF}}
    };
    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].known, rows[i].want);
    pix_in.valid <= 1'b0;

    // extremes, overflow and underflow prescale, 0.9 shrink, coarse ramps
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: set_tone(16'h7FFF, 16'h7FFF, 1'b0);
        1: set_tone(16'h8000, 16'h7FFF, 1'b0);
        2: set_tone(16'h8000, 16'h8000, 1'b0);
        3: set_tone(16'h7FFF, 16'h8000, 1'b0);
        4: set_tone(16'h7FFF, 16'h7FFF, 1'b1);
        5: set_tone(16'h8000, 16'h8000, 1'b1);
        6: set_tone(16'h0000, 16'h4000, 1'b1);
        default: set_tone(16'h1234, 16'h0000, 1'b1);
      endcase
      rows = '{
        '{'{8'd0, 8'd255, 8'd216}, 1'b0, '0},
        '{'{8'd40, 8'd128, 8'd127}, 1'b0, '0},
        '{'{8'hAA, 8'h55, 8'd1}, 1'b0, '0}
      };
      foreach (rows[i]) send_pixel(rows[i].pix, rows[i].known, rows[i].want);
      pix_in.valid <= 1'b0;
    end

    // random settings, each with a batch of random pixels
    for (int ph = 0; ph < 12; ph++) begin
      b_pick = 16'($urandom);
      c_pick = 16'($urandom);
      if (ph % 3 == 0) b_pick = {$urandom_range(1) ? 2'b01 : 2'b10, 14'($urandom)};
      set_tone(b_pick, c_pick, ph % 4 == 3);
      calm = (ph == 5);
      for (int n = 0; n < 75; n++) send_pixel(rand_pixel(), 1'b0, '0);
      pix_in.valid <= 1'b0;
      calm = 1'b0;
    end
    set_tone(16'h0000, 16'h0000, 1'b0);

    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_pixels.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end
endmodule
